// ----- hdl/tfst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_pkg
// Types, constants and the TCP state transition function shared by the
// flow state tracker's controller, datapath and top level.
// ----------------------------------------------------------------------------
package tfst_pkg;

   localparam int FLOW_ENTRIES = 1024;
   localparam int SLOT_W       = $clog2(FLOW_ENTRIES);
   localparam int SLOT_FIELD_W = 10;
   localparam int STATE_W      = 4;
   localparam int FLOW_ID_W    = 32;

   typedef enum logic [STATE_W-1:0] {
      ST_INIT        = 4'd0,
      ST_SYN_SENT    = 4'd1,
      ST_SYN_RECV    = 4'd2,
      ST_ESTABLISHED = 4'd3,
      ST_FIN_SENT_1  = 4'd4,
      ST_FIN_WAIT_1  = 4'd5,
      ST_FIN_SENT_2  = 4'd6,
      ST_CLOSED      = 4'd7,
      ST_UNKNOWN     = 4'd8
   } conn_state_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_LOOKUP,
      CS_UPDATE
   } ctrl_state_type;

   typedef struct packed {
      logic syn;
      logic ack;
      logic fin;
      logic rst;
   } tcp_flags_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic rd_en;
      logic commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_full;
   } dp_status_type;

   function automatic conn_state_type tcp_next(input conn_state_type cur,
                                               input tcp_flags_type  f);
      conn_state_type nxt;
      nxt = ST_UNKNOWN;
      case (cur)
         ST_INIT: begin
            if (f.syn) nxt = ST_SYN_SENT;
         end
         ST_SYN_SENT: begin
            if (f.rst) nxt = ST_CLOSED;
            else if (f.syn && f.ack) nxt = ST_SYN_RECV;
         end
         ST_SYN_RECV: begin
            if (f.rst) nxt = ST_CLOSED;
            else if (f.ack) nxt = ST_ESTABLISHED;
         end
         ST_ESTABLISHED: begin
            if (f.rst) nxt = ST_CLOSED;
            else if (f.fin) nxt = ST_FIN_SENT_1;
         end
         ST_FIN_SENT_1: begin
            if (f.rst) nxt = ST_CLOSED;
            else if (f.fin && f.ack) nxt = ST_FIN_SENT_2;
            else if (f.ack) nxt = ST_FIN_WAIT_1;
         end
         ST_FIN_WAIT_1: begin
            if (f.rst) nxt = ST_CLOSED;
            else if (f.fin) nxt = ST_FIN_SENT_2;
         end
         ST_FIN_SENT_2: begin
            if (f.ack) nxt = ST_CLOSED;
         end
         ST_CLOSED: begin
            if (f.ack) nxt = ST_CLOSED;
         end
         default: begin
            nxt = ST_UNKNOWN;
         end
      endcase
      return nxt;
   endfunction

endpackage

// ----- hdl/tfst_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tfst_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tfst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_ctrl
// Sequencer for one packet: accept, read the slot state, then update and
// hand the result to the output register.
// ----------------------------------------------------------------------------
module tfst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    rsp_stall,
   input  tfst_pkg::dp_status_type status,
   output tfst_pkg::dp_cmd_type    cmd
);
   import tfst_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           out_blocked;

   assign out_blocked = status.out_full && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.rd_en   = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CS_LOOKUP;
            end
         end
         CS_LOOKUP: begin
            cmd.rd_en = 1'b1;
            state_in  = CS_UPDATE;
         end
         CS_UPDATE: begin
            // The result can only be loaded once the output register has room.
            if (!out_blocked) begin
               cmd.commit = 1'b1;
               state_in   = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == CS_LOOKUP)
      else $error("accepted transaction did not start a lookup");

   a_lookup_to_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_LOOKUP) |=> state_ff == CS_UPDATE)
      else $error("lookup was not followed by an update");

   a_commit_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(status.out_full && rsp_stall))
      else $error("result committed over a pending result");

endmodule

// ----- hdl/tfst_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_dp
// Datapath: packet holding registers, flow state memory, flow id counter,
// TCP transition logic and the result register.
// ----------------------------------------------------------------------------
module tfst_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tfst_pkg::dp_cmd_type                  cmd,
   output tfst_pkg::dp_status_type               status,
   input  logic [tfst_pkg::SLOT_FIELD_W-1:0]     req_flow_slot,
   input  logic                                  req_new_flow,
   input  logic                                  req_is_ip,
   input  logic                                  req_is_tcp,
   input  logic                                  req_flag_syn,
   input  logic                                  req_flag_ack,
   input  logic                                  req_flag_fin,
   input  logic                                  req_flag_rst,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [tfst_pkg::STATE_W-1:0]          rsp_conn_state,
   output logic                                  rsp_state_updated,
   output logic [tfst_pkg::FLOW_ID_W-1:0]        rsp_assigned_id,
   output logic                                  rsp_id_valid
);
   import tfst_pkg::*;

   // Packet holding registers.
   logic [SLOT_W-1:0]    slot_ff;
   logic                 new_ff;
   logic                 tcp_ff;
   tcp_flags_type        flags_ff;

   logic [FLOW_ID_W-1:0] flow_id_counter_ff;
   logic [FLOW_ID_W-1:0] flow_id_counter_in;

   logic                 out_full_ff;
   logic                 out_full_in;
   logic [STATE_W-1:0]   out_state_ff;
   logic                 out_updated_ff;
   logic [FLOW_ID_W-1:0] out_id_ff;
   logic                 out_id_valid_ff;

   logic [STATE_W-1:0]   rd_data;
   conn_state_type       cur_state;
   conn_state_type       next_state;
   logic                 wr_en;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         slot_ff      <= req_flow_slot[SLOT_W-1:0];
         new_ff       <= req_new_flow;
         tcp_ff       <= req_is_ip && req_is_tcp;
         flags_ff.syn <= req_flag_syn;
         flags_ff.ack <= req_flag_ack;
         flags_ff.fin <= req_flag_fin;
         flags_ff.rst <= req_flag_rst;
      end
   end

   tfst_ram #(
      .WIDTH (STATE_W),
      .DEPTH (FLOW_ENTRIES)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (next_state),
      .rd_en   (cmd.rd_en),
      .rd_addr (slot_ff),
      .rd_data (rd_data)
   );

   // A new flow starts from INIT regardless of what the slot held.
   always_comb begin
      cur_state  = new_ff ? ST_INIT : conn_state_type'(rd_data);
      next_state = tcp_ff ? tcp_next(cur_state, flags_ff) : cur_state;
      wr_en      = cmd.commit && (new_ff || tcp_ff);
   end

   assign flow_id_counter_in = (cmd.commit && new_ff) ?
                               flow_id_counter_ff + FLOW_ID_W'(1) : flow_id_counter_ff;

   assign out_full_in = cmd.commit || (out_full_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_id_counter_ff <= '0;
         out_full_ff        <= 1'b0;
      end else begin
         flow_id_counter_ff <= flow_id_counter_in;
         out_full_ff        <= out_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_state_ff    <= next_state;
         out_updated_ff  <= tcp_ff;
         out_id_ff       <= new_ff ? flow_id_counter_ff : '0;
         out_id_valid_ff <= new_ff;
      end
   end

   assign status.out_full   = out_full_ff;
   assign rsp_valid         = out_full_ff;
   assign rsp_conn_state    = out_state_ff;
   assign rsp_state_updated = out_updated_ff;
   assign rsp_assigned_id   = out_id_ff;
   assign rsp_id_valid      = out_id_valid_ff;

   a_commit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

   a_counter_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && new_ff) |=> flow_id_counter_ff == $past(flow_id_counter_ff) + 32'd1)
      else $error("flow id counter did not advance for a new flow");

   a_counter_holds: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && new_ff) |=> $stable(flow_id_counter_ff))
      else $error("flow id counter moved without a new flow");

   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_id_valid) |-> rsp_assigned_id == '0)
      else $error("flow id present without a new flow");

endmodule

// ----- hdl/tcp_flow_state_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker_core
// Per-flow TCP connection state tracker with a wrapping flow id allocator.
// ----------------------------------------------------------------------------
// Each packet is accepted, its slot is then read from the single-port-read
// state memory, and then the new state is computed, written back and loaded
// into the result register. The next packet is accepted right
// after that, even while the previous result still waits on rsp_stall; the
// update step waits only when a result is still pending in the output
// register. The state memory is not cleared after reset: a slot must be
// opened by a packet with new_flow set before its state is meaningful.
// ----------------------------------------------------------------------------
module tcp_flow_state_tracker_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [tfst_pkg::SLOT_FIELD_W-1:0] req_flow_slot,
   input  logic                              req_new_flow,
   input  logic                              req_is_ip,
   input  logic                              req_is_tcp,
   input  logic                              req_flag_syn,
   input  logic                              req_flag_ack,
   input  logic                              req_flag_fin,
   input  logic                              req_flag_rst,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tfst_pkg::STATE_W-1:0]      rsp_conn_state,
   output logic                              rsp_state_updated,
   output logic [tfst_pkg::FLOW_ID_W-1:0]    rsp_assigned_id,
   output logic                              rsp_id_valid
);
   import tfst_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tfst_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_flow_slot     (req_flow_slot),
      .req_new_flow      (req_new_flow),
      .req_is_ip         (req_is_ip),
      .req_is_tcp        (req_is_tcp),
      .req_flag_syn      (req_flag_syn),
      .req_flag_ack      (req_flag_ack),
      .req_flag_fin      (req_flag_fin),
      .req_flag_rst      (req_flag_rst),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_conn_state    (rsp_conn_state),
      .rsp_state_updated (rsp_state_updated),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_id_valid      (rsp_id_valid)
   );

endmodule

// ----- test/tcp_flow_state_tracker_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker_core_tb
// Checks the per-flow TCP state tracker against a predictor of its own.
// Directed packets walk a flow through every connection state, the ACK and
// lone-FIN exits of FIN_SENT_1 and the non-TCP cases. Random traffic then
// runs several flows at once, mostly through well-formed handshakes, mixed
// with broken flag sets and non-TCP packets. The sender works in bursts and
// the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tcp_flow_state_tracker_core_tb;
   import tfst_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int MAX_PRINTED    = 40;
   localparam int FLOW_POOL      = 8;

   localparam tcp_flags_type F_NONE    = 4'b0000;
   localparam tcp_flags_type F_SYN     = 4'b1000;
   localparam tcp_flags_type F_ACK     = 4'b0100;
   localparam tcp_flags_type F_FIN     = 4'b0010;
   localparam tcp_flags_type F_SYN_ACK = 4'b1100;
   localparam tcp_flags_type F_FIN_ACK = 4'b0110;
   localparam tcp_flags_type F_ALL     = 4'b1111;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BURST
   } stall_mode_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0] flow_slot;
      logic                    new_flow;
      logic                    is_ip;
      logic                    is_tcp;
      tcp_flags_type           flags;
   } packet_type;

   typedef struct packed {
      conn_state_type        conn_state;
      logic                  state_updated;
      logic [FLOW_ID_W-1:0]  assigned_id;
      logic                  id_valid;
   } tracker_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [SLOT_FIELD_W-1:0] req_flow_slot = '0;
   logic                    req_new_flow = 1'b0;
   logic                    req_is_ip = 1'b0;
   logic                    req_is_tcp = 1'b0;
   logic                    req_flag_syn = 1'b0;
   logic                    req_flag_ack = 1'b0;
   logic                    req_flag_fin = 1'b0;
   logic                    req_flag_rst = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATE_W-1:0]      rsp_conn_state;
   logic                    rsp_state_updated;
   logic [FLOW_ID_W-1:0]    rsp_assigned_id;
   logic                    rsp_id_valid;

   // Predicted tracker state.
   conn_state_type        model_states [FLOW_ENTRIES];
   bit                    slot_open [FLOW_ENTRIES];
   int                    open_slots [$];
   logic [FLOW_ID_W-1:0]  model_flow_id = '0;

   tracker_result_type    pending_results [$];
   int                    error_count = 0;
   int                    results_seen = 0;
   int                    burst_left = 0;
   int                    idle_cycles = 0;
   int                    stall_tick = 0;
   stall_mode_type        stall_mode = STALL_NONE;

   tcp_flow_state_tracker_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_flow_slot     (req_flow_slot),
      .req_new_flow      (req_new_flow),
      .req_is_ip         (req_is_ip),
      .req_is_tcp        (req_is_tcp),
      .req_flag_syn      (req_flag_syn),
      .req_flag_ack      (req_flag_ack),
      .req_flag_fin      (req_flag_fin),
      .req_flag_rst      (req_flag_rst),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_conn_state    (rsp_conn_state),
      .rsp_state_updated (rsp_state_updated),
      .rsp_assigned_id   (rsp_assigned_id),
      .rsp_id_valid      (rsp_id_valid)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic conn_state_type advance_tcp(input conn_state_type cur,
                                                  input tcp_flags_type  f);
      conn_state_type nxt;
      case (cur)
         ST_INIT:        nxt = f.syn ? ST_SYN_SENT : ST_UNKNOWN;
         ST_SYN_SENT:    nxt = f.rst ? ST_CLOSED :
                               (f.syn && f.ack) ? ST_SYN_RECV : ST_UNKNOWN;
         ST_SYN_RECV:    nxt = f.rst ? ST_CLOSED : f.ack ? ST_ESTABLISHED : ST_UNKNOWN;
         ST_ESTABLISHED: nxt = f.rst ? ST_CLOSED : f.fin ? ST_FIN_SENT_1 : ST_UNKNOWN;
         ST_FIN_SENT_1:  nxt = f.rst ? ST_CLOSED :
                               (f.fin && f.ack) ? ST_FIN_SENT_2 :
                               f.ack ? ST_FIN_WAIT_1 : ST_UNKNOWN;
         ST_FIN_WAIT_1:  nxt = f.rst ? ST_CLOSED : f.fin ? ST_FIN_SENT_2 : ST_UNKNOWN;
         ST_FIN_SENT_2,
         ST_CLOSED:      nxt = f.ack ? ST_CLOSED : ST_UNKNOWN;
         default:        nxt = ST_UNKNOWN;
      endcase
      return nxt;
   endfunction

   // Applies one accepted packet to the predicted flow states.
   function automatic tracker_result_type track_packet(input packet_type p);
      tracker_result_type r;
      int                 slot;
      slot            = int'(p.flow_slot) % FLOW_ENTRIES;
      r.assigned_id   = '0;
      r.id_valid      = 1'b0;
      r.state_updated = 1'b0;
      if (p.new_flow) begin
         model_states[slot] = ST_INIT;
         if (!slot_open[slot]) begin
            slot_open[slot] = 1'b1;
            open_slots.push_back(slot);
         end
         r.assigned_id = model_flow_id;
         r.id_valid    = 1'b1;
         model_flow_id = model_flow_id + FLOW_ID_W'(1);
      end
      if (p.is_ip && p.is_tcp) begin
         model_states[slot] = advance_tcp(model_states[slot], p.flags);
         r.state_updated    = 1'b1;
      end
      r.conn_state = model_states[slot];
      return r;
   endfunction

   // Flags that move a flow one step further along a normal connection, or, at random, reset it.
   function automatic tcp_flags_type well_formed_flags(input conn_state_type st);
      tcp_flags_type f;
      logic          do_reset;
      f        = tcp_flags_type'($urandom_range(0, 15));
      do_reset = ($urandom_range(0, 9) == 0);
      case (st)
         ST_INIT:        f.syn = 1'b1;
         ST_SYN_SENT:    if (!do_reset) f = '{syn: 1'b1, ack: 1'b1, fin: f.fin, rst: 1'b0};
         ST_SYN_RECV:    if (!do_reset) f = '{syn: f.syn, ack: 1'b1, fin: f.fin, rst: 1'b0};
         ST_ESTABLISHED: if (!do_reset) f = '{syn: f.syn, ack: f.ack, fin: 1'b1, rst: 1'b0};
         ST_FIN_SENT_1:  if (!do_reset) f = '{syn: f.syn, ack: 1'b1, fin: f.fin, rst: 1'b0};
         ST_FIN_WAIT_1:  if (!do_reset) f = '{syn: f.syn, ack: f.ack, fin: 1'b1, rst: 1'b0};
         ST_FIN_SENT_2,
         ST_CLOSED:      f.ack = 1'b1;
         default:        ;
      endcase
      if (do_reset && st != ST_INIT) f.rst = 1'b1;
      return f;
   endfunction

   function automatic packet_type make_packet(input int slot, input logic new_flow,
                                              input logic is_ip, input logic is_tcp,
                                              input tcp_flags_type flags);
      packet_type p;
      p.flow_slot = slot[SLOT_FIELD_W-1:0];
      p.new_flow  = new_flow;
      p.is_ip     = is_ip;
      p.is_tcp    = is_tcp;
      p.flags     = flags;
      return p;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED) $display("ERROR at %0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   // Drives one packet and waits until the tracker takes it.
   task automatic send_packet(input packet_type p);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_flow_slot <= p.flow_slot;
      req_new_flow  <= p.new_flow;
      req_is_ip     <= p.is_ip;
      req_is_tcp    <= p.is_tcp;
      req_flag_syn  <= p.flags.syn;
      req_flag_ack  <= p.flags.ack;
      req_flag_fin  <= p.flags.fin;
      req_flag_rst  <= p.flags.rst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(track_packet(p));
   endtask

   task automatic send_tcp(input int slot, input logic new_flow, input tcp_flags_type f);
      send_packet(make_packet(slot, new_flow, 1'b1, 1'b1, f));
   endtask

   // A full connection on slot 0, from the opening SYN through CLOSED and
   // into the sticky UNKNOWN state.
   task automatic test_full_lifecycle();
      send_tcp(0, 1'b1, F_SYN);
      send_tcp(0, 1'b0, F_SYN_ACK);
      send_tcp(0, 1'b0, F_ACK);
      send_tcp(0, 1'b0, F_FIN);
      send_tcp(0, 1'b0, F_ACK);
      send_tcp(0, 1'b0, F_FIN);
      send_tcp(0, 1'b0, F_ACK);
      send_tcp(0, 1'b0, F_ACK);
      send_tcp(0, 1'b0, F_NONE);
      send_tcp(0, 1'b0, F_ALL);
   endtask

   // FIN alone in FIN_SENT_1 must end in UNKNOWN, not in the FIN_WAIT_1 rules.
   task automatic test_fin_sent_1_exit();
      send_tcp(FLOW_ENTRIES - 1, 1'b1, F_ALL);
      send_tcp(FLOW_ENTRIES - 1, 1'b0, F_SYN_ACK);
      send_tcp(FLOW_ENTRIES - 1, 1'b0, F_ACK);
      send_tcp(FLOW_ENTRIES - 1, 1'b0, F_FIN);
      send_tcp(FLOW_ENTRIES - 1, 1'b0, F_FIN);
   endtask

   // Non-TCP packets leave the state alone; is_tcp without IP is ignored.
   task automatic test_non_tcp();
      send_packet(make_packet(FLOW_ENTRIES - 1, 1'b1, 1'b1, 1'b0, F_ALL));
      send_packet(make_packet(0, 1'b0, 1'b0, 1'b1, F_ALL));
      send_packet(make_packet(0, 1'b0, 1'b1, 1'b0, F_SYN));
      send_packet(make_packet(FLOW_ENTRIES - 1, 1'b0, 1'b0, 1'b0, F_FIN_ACK));
      send_tcp(FLOW_ENTRIES - 1, 1'b0, F_ACK);
   endtask

   // Several flows in flight at once, mostly following normal connections.
   task automatic test_random_flows(input int count);
      int             active [FLOW_POOL];
      int             idx;
      int             slot;
      int             pick;
      conn_state_type st;
      foreach (active[i]) active[i] = $urandom_range(0, FLOW_ENTRIES - 1);
      repeat (count) begin
         idx  = $urandom_range(0, FLOW_POOL - 1);
         pick = $urandom_range(0, 99);
         if (pick < 8) active[idx] = $urandom_range(0, FLOW_ENTRIES - 1);
         slot = active[idx];
         st   = model_states[slot];
         if (!slot_open[slot] || pick < 8 ||
             ((st == ST_CLOSED || st == ST_UNKNOWN) && pick < 60)) begin
            send_tcp(slot, 1'b1, well_formed_flags(ST_INIT));
         end else if (pick < 14) begin
            pick = $urandom_range(0, 2);
            send_packet(make_packet(slot, 1'b0, pick[0], pick[1],
                                    tcp_flags_type'($urandom_range(0, 15))));
         end else if (pick < 20) begin
            send_tcp(slot, 1'b0, tcp_flags_type'($urandom_range(0, 15)));
         end else begin
            send_tcp(slot, 1'b0, well_formed_flags(st));
         end
      end
   endtask

   // Fully random packets; slots without an open flow only get new flows.
   task automatic test_random_noise(input int count);
      int   slot;
      logic new_flow;
      repeat (count) begin
         new_flow = ($urandom_range(0, 4) == 0);
         if (new_flow) slot = $urandom_range(0, FLOW_ENTRIES - 1);
         else slot = open_slots[$urandom_range(0, open_slots.size() - 1)];
         send_packet(make_packet(slot, new_flow, $urandom_range(0, 1), $urandom_range(0, 1),
                                 tcp_flags_type'($urandom_range(0, 15))));
      end
   endtask

   always @(posedge clock) begin
      stall_tick = stall_tick + 1;
      if (stall_tick % 64 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (stall_tick % 16) < 11;
      endcase
   end

   always @(posedge clock) begin : check_results
      tracker_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no packet outstanding",
                                      results_seen));
         end else begin
            want = pending_results.pop_front();
            if (rsp_conn_state !== want.conn_state)
               report_mismatch($sformatf("result %0d conn_state %0d, expected %0d",
                                         results_seen, rsp_conn_state, want.conn_state));
            if (rsp_state_updated !== want.state_updated)
               report_mismatch($sformatf("result %0d state_updated %0b, expected %0b",
                                         results_seen, rsp_state_updated,
                                         want.state_updated));
            if (rsp_assigned_id !== want.assigned_id)
               report_mismatch($sformatf("result %0d assigned_id %0d, expected %0d",
                                         results_seen, rsp_assigned_id, want.assigned_id));
            if (rsp_id_valid !== want.id_valid)
               report_mismatch($sformatf("result %0d id_valid %0b, expected %0b",
                                         results_seen, rsp_id_valid, want.id_valid));
         end
      end
   end

   // Ends the run when no transaction has happened on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_full_lifecycle();
      test_fin_sent_1_exit();
      test_non_tcp();
      test_random_flows(1000);
      test_random_noise(250);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
